// ===== rtl/jtw_pkg.sv =====
// jtw_pkg: shared types, constants and the tap transition function
// for the jtag tap state walker; no dependencies
package jtw_pkg;

   localparam int RESET_CLOCKS = 5;
   localparam int MAX_PULSES   = 16;
   localparam int CNT_W        = $clog2(MAX_PULSES);
   localparam int RST_PULSES   = (RESET_CLOCKS > MAX_PULSES) ? MAX_PULSES : RESET_CLOCKS;
   localparam logic [CNT_W-1:0] RST_LAST_CNT = CNT_W'(RST_PULSES - 1);
   localparam logic [CNT_W-1:0] MAX_LAST_CNT = CNT_W'(MAX_PULSES - 1);

   typedef enum logic [3:0] {
      TAP_TLR    = 4'd0,
      TAP_RTI    = 4'd1,
      TAP_SEL_DR = 4'd2,
      TAP_CAP_DR = 4'd3,
      TAP_SHF_DR = 4'd4,
      TAP_EX1_DR = 4'd5,
      TAP_PAU_DR = 4'd6,
      TAP_EX2_DR = 4'd7,
      TAP_UPD_DR = 4'd8,
      TAP_SEL_IR = 4'd9,
      TAP_CAP_IR = 4'd10,
      TAP_SHF_IR = 4'd11,
      TAP_EX1_IR = 4'd12,
      TAP_PAU_IR = 4'd13,
      TAP_EX2_IR = 4'd14,
      TAP_UPD_IR = 4'd15
   } tap_state_type;

   typedef enum logic {
      ACT_GOTO  = 1'b0,
      ACT_RESET = 1'b1
   } action_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_WALK = 1'b1
   } ctl_state_type;

   typedef struct packed {
      logic load;   // latch a new request
      logic step;   // emit one tck pulse into the output register
   } jtw_cmd_type;

   typedef struct packed {
      logic at_goal;    // offered goto target equals tracked state
      logic out_free;   // output register can take a beat this cycle
      logic step_last;  // pulse being formed now ends the action
   } jtw_status_type;

   typedef struct packed {
      logic          tms;
      tap_state_type nxt;
   } walk_type;

   // one tap transition toward goal
   function automatic walk_type walk_one(tap_state_type cur, tap_state_type goal);
      walk_type w;
      w.tms = 1'b1;
      w.nxt = TAP_TLR;
      unique case (cur)
         TAP_TLR: begin
            w.tms = 1'b0; w.nxt = TAP_RTI;
         end
         TAP_RTI: begin
            w.tms = 1'b1; w.nxt = TAP_SEL_DR;
         end
         TAP_SEL_DR: begin
            if (goal == TAP_RTI || (goal >= TAP_SEL_DR && goal <= TAP_UPD_DR)) begin
               w.tms = 1'b0; w.nxt = TAP_CAP_DR;
            end else begin
               w.tms = 1'b1; w.nxt = TAP_SEL_IR;
            end
         end
         TAP_CAP_DR: begin
            if (goal == TAP_SHF_DR) begin
               w.tms = 1'b0; w.nxt = TAP_SHF_DR;
            end else begin
               w.tms = 1'b1; w.nxt = TAP_EX1_DR;
            end
         end
         TAP_SHF_DR: begin
            w.tms = 1'b1; w.nxt = TAP_EX1_DR;
         end
         TAP_EX1_DR: begin
            if (goal == TAP_PAU_DR || goal == TAP_EX2_DR) begin
               w.tms = 1'b0; w.nxt = TAP_PAU_DR;
            end else begin
               w.tms = 1'b1; w.nxt = TAP_UPD_DR;
            end
         end
         TAP_PAU_DR: begin
            w.tms = 1'b1; w.nxt = TAP_EX2_DR;
         end
         TAP_EX2_DR: begin
            if (goal == TAP_SHF_DR || goal == TAP_EX1_DR || goal == TAP_PAU_DR) begin
               w.tms = 1'b0; w.nxt = TAP_SHF_DR;
            end else begin
               w.tms = 1'b1; w.nxt = TAP_UPD_DR;
            end
         end
         TAP_UPD_DR, TAP_UPD_IR: begin
            if (goal == TAP_RTI) begin
               w.tms = 1'b0; w.nxt = TAP_RTI;
            end else begin
               w.tms = 1'b1; w.nxt = TAP_SEL_DR;
            end
         end
         TAP_SEL_IR: begin
            if (goal != TAP_TLR) begin
               w.tms = 1'b0; w.nxt = TAP_CAP_IR;
            end else begin
               w.tms = 1'b1; w.nxt = TAP_TLR;
            end
         end
         TAP_CAP_IR: begin
            if (goal == TAP_SHF_IR) begin
               w.tms = 1'b0; w.nxt = TAP_SHF_IR;
            end else begin
               w.tms = 1'b1; w.nxt = TAP_EX1_IR;
            end
         end
         TAP_SHF_IR: begin
            w.tms = 1'b1; w.nxt = TAP_EX1_IR;
         end
         TAP_EX1_IR: begin
            if (goal == TAP_PAU_IR || goal == TAP_EX2_IR) begin
               w.tms = 1'b0; w.nxt = TAP_PAU_IR;
            end else begin
               w.tms = 1'b1; w.nxt = TAP_UPD_IR;
            end
         end
         TAP_PAU_IR: begin
            w.tms = 1'b1; w.nxt = TAP_EX2_IR;
         end
         TAP_EX2_IR: begin
            if (goal == TAP_SHF_IR || goal == TAP_EX1_IR || goal == TAP_PAU_IR) begin
               w.tms = 1'b0; w.nxt = TAP_SHF_IR;
            end else begin
               w.tms = 1'b1; w.nxt = TAP_UPD_IR;
            end
         end
         default: begin
            w.tms = 1'b1; w.nxt = TAP_TLR;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/jtw_ctrl.sv =====
// jtw_ctrl: request/walk controller for the tap state walker
// depends on jtw_pkg
module jtw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_action,
   output logic                    req_ready,
   input  jtw_pkg::jtw_status_type status,
   output jtw_pkg::jtw_cmd_type    cmd
);
   import jtw_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         CTL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               // goto to the current state gives no beat
               if (req_action == ACT_RESET || !status.at_goal) begin
                  state_in = CTL_WALK;
               end
            end
         end
         CTL_WALK: begin
            if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.step_last) begin
                  state_in = CTL_IDLE;
               end
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/jtw_datapath.sv =====
// jtw_datapath: tracked tap state, pulse counter and output register
// depends on jtw_pkg
module jtw_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_action,
   input  logic [3:0]              req_target_state,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic                    rsp_tms_bit,
   output logic                    rsp_last_step,
   input  jtw_pkg::jtw_cmd_type    cmd,
   output jtw_pkg::jtw_status_type status
);
   import jtw_pkg::*;

   tap_state_type    tap_state_ff, tap_state_in;
   tap_state_type    goal_ff;
   logic             action_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             rsp_valid_ff;
   logic             tms_ff, last_ff;
   walk_type         walk;
   logic             tms_in, last_in;

   assign walk = walk_one(tap_state_ff, goal_ff);

   always_comb begin
      if (action_ff == ACT_RESET) begin
         tms_in       = 1'b1;
         last_in      = (cnt_ff == RST_LAST_CNT);
         tap_state_in = TAP_TLR;
      end else begin
         tms_in       = walk.tms;
         last_in      = (walk.nxt == goal_ff) || (cnt_ff == MAX_LAST_CNT);
         tap_state_in = walk.nxt;
      end
   end

   assign status.at_goal   = (tap_state_type'(req_target_state) == tap_state_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign status.step_last = last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_state_ff <= TAP_TLR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.step) begin
            rsp_valid_ff <= 1'b1;
            if (action_ff == ACT_GOTO || last_in) begin
               tap_state_ff <= tap_state_in;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         goal_ff   <= tap_state_type'(req_target_state);
         cnt_ff    <= '0;
      end else if (cmd.step) begin
         cnt_ff    <= cnt_ff + 1'b1;
      end
      if (cmd.step) begin
         tms_ff  <= tms_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tms_bit   = tms_ff;
   assign rsp_last_step = last_ff;

   a_step_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (!rsp_valid_ff || rsp_ready))
      else $error("pulse formed while output register is full");

   a_no_load_and_step: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.step))
      else $error("load and step in the same cycle");

   a_reset_lands_tlr: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && action_ff == ACT_RESET && last_in) |=> (tap_state_ff == TAP_TLR))
      else $error("reset action did not end in test-logic-reset");

   a_goto_ends_at_goal: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && action_ff == ACT_GOTO && last_in) |=> (tap_state_ff == goal_ff))
      else $error("goto walk ended away from its target");

endmodule

// ===== rtl/jtag_tap_state_walker.sv =====
// jtag_tap_state_walker: top level of the jtag tap state walker
// depends on jtw_pkg, jtw_ctrl and jtw_datapath
//
// usage
//   req channel: one beat is an action; goto walks the tracked tap state to
//   req_target_state, reset forces test-logic-reset with RESET_CLOCKS pulses
//   of tms high (target ignored)
//   rsp channel: one beat per tck pulse, rsp_tms_bit is the tms level for that
//   pulse, rsp_last_step marks the final pulse of the action
//   a goto to the state that is already tracked gives no rsp beat at all
// order and throughput
//   the walk starts in the cycle after the req beat, and its first rsp beat is
//   registered once the output register is free; then one beat per cycle
//   while rsp_ready is high; the controller walks one action at a time,
//   and a new req beat is taken as soon as the last pulse is registered
// reset: controller idle, tracked state test-logic-reset, no rsp beat pending
// stall: while rsp_ready is low the held beat stays and the walk pauses;
//   req_ready stays low until the running action has registered its last pulse
module jtag_tap_state_walker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [3:0] req_target_state,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_tms_bit,
   output logic       rsp_last_step
);
   import jtw_pkg::*;

   jtw_cmd_type    cmd;
   jtw_status_type status;

   // sequencing: accept, then one step per free output slot
   jtw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // tracked tap state, transition logic and the rsp output register
   jtw_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_action       (req_action),
      .req_target_state (req_target_state),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_tms_bit      (rsp_tms_bit),
      .rsp_last_step    (rsp_last_step),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ===== tb/jtag_tap_state_walker_tb.sv =====
// jtag_tap_state_walker_tb: self-checking testbench for the tap state walker,
// with a tms pulse predictor and scoreboard class and randomized handshakes
// depends on jtw_pkg and jtag_tap_state_walker
module jtag_tap_state_walker_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import jtw_pkg::*;

   localparam int WALK_CAP     = 16;       // safeguard bound on one goto walk
   localparam int RANDOM_GOAL  = 140;      // random actions that make pulses
   localparam int CYCLE_LIMIT  = 200000;   // far above the slowest clean run
   localparam int DRAIN_CYCLES = 20;       // quiet time after the last pulse

   // predicts tms pulses per action and matches them against rsp beats
   class tap_walk_scoreboard;
      typedef struct packed {
         logic tms;
         logic last;
      } pulse_type;

      tap_state_type tracked;
      pulse_type     pulse_q[$];
      int unsigned   errors;

      function new();
         tracked = TAP_TLR;
         errors  = 0;
      endfunction

      // one tck pulse toward goal; moves the tracked state, returns tms
      function logic hop(tap_state_type goal);
         bit            ir_col;
         bit            to_dr;
         logic          tms;
         tap_state_type cap, shf, ex1, pau, ex2, upd, nxt;
         ir_col = (tracked >= TAP_SEL_IR);
         cap = ir_col ? TAP_CAP_IR : TAP_CAP_DR;
         shf = ir_col ? TAP_SHF_IR : TAP_SHF_DR;
         ex1 = ir_col ? TAP_EX1_IR : TAP_EX1_DR;
         pau = ir_col ? TAP_PAU_IR : TAP_PAU_DR;
         ex2 = ir_col ? TAP_EX2_IR : TAP_EX2_DR;
         upd = ir_col ? TAP_UPD_IR : TAP_UPD_DR;
         to_dr = (goal == TAP_RTI) || (goal >= TAP_SEL_DR && goal <= TAP_UPD_DR);
         if (tracked == TAP_TLR) begin
            tms = 1'b0; nxt = TAP_RTI;
         end else if (tracked == TAP_RTI) begin
            tms = 1'b1; nxt = TAP_SEL_DR;
         end else if (tracked == TAP_SEL_DR) begin
            tms = !to_dr; nxt = to_dr ? TAP_CAP_DR : TAP_SEL_IR;
         end else if (tracked == TAP_SEL_IR) begin
            tms = (goal == TAP_TLR); nxt = tms ? TAP_TLR : TAP_CAP_IR;
         end else if (tracked == upd) begin
            tms = (goal != TAP_RTI); nxt = tms ? TAP_SEL_DR : TAP_RTI;
         end else if (tracked == cap) begin
            tms = (goal != shf); nxt = tms ? ex1 : shf;
         end else if (tracked == shf) begin
            tms = 1'b1; nxt = ex1;
         end else if (tracked == ex1) begin
            tms = !(goal == pau || goal == ex2); nxt = tms ? upd : pau;
         end else if (tracked == pau) begin
            tms = 1'b1; nxt = ex2;
         end else begin
            tms = !(goal == shf || goal == ex1 || goal == pau); nxt = tms ? upd : shf;
         end
         tracked = nxt;
         return tms;
      endfunction

      // queue the pulses of one accepted action, return how many
      function int note_request(action_type act, tap_state_type goal);
         int        n;
         int        count;
         pulse_type p;
         n = 0;
         if (act == ACT_RESET) begin
            count = (RESET_CLOCKS > WALK_CAP) ? WALK_CAP : RESET_CLOCKS;
            for (n = 0; n < count; n++) begin
               p.tms  = 1'b1;
               p.last = (n + 1 == count);
               pulse_q.push_back(p);
            end
            tracked = TAP_TLR;
         end else begin
            while (tracked != goal && n < WALK_CAP) begin
               p.tms  = hop(goal);
               p.last = (tracked == goal) || (n + 1 == WALK_CAP);
               pulse_q.push_back(p);
               n++;
            end
         end
         return n;
      endfunction

      function void flag(string what);
         if (errors < 10)
            $display("[%0t] mismatch: %s", $time, what);
         errors++;
      endfunction

      function void check_pulse(logic tms, logic last);
         pulse_type want;
         if (pulse_q.size() == 0) begin
            flag($sformatf("rsp beat with none expected (tms %b last %b)", tms, last));
            return;
         end
         want = pulse_q.pop_front();
         if (tms !== want.tms)
            flag($sformatf("tms_bit expected %b actual %b", want.tms, tms));
         if (last !== want.last)
            flag($sformatf("last_step expected %b actual %b", want.last, last));
      endfunction

      function int pending();
         return pulse_q.size();
      endfunction
   endclass

   // all block inputs start at known values
   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_action       = 1'b0;
   logic [3:0] req_target_state = 4'd0;
   logic       rsp_ready        = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic       rsp_tms_bit;
   logic       rsp_last_step;

   tap_walk_scoreboard sb;
   bit                 no_idle = 1'b0;   // set for back-to-back stretches
   int unsigned        cycles  = 0;

   jtag_tap_state_walker u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_target_state (req_target_state),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tms_bit      (rsp_tms_bit),
      .rsp_last_step    (rsp_last_step)
   );

   always #1 clock = ~clock;

   // watchdog: a hang or a lost pulse ends here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("jtag_tap_state_walker_tb: done, errors");
         $finish;
      end
   end

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 7);
   endfunction

   // one req beat; valid is only dropped when a gap is taken, so a
   // back-to-back beat never sees valid lowered and raised in one step
   task automatic send_action(input action_type act, input tap_state_type goal,
                              output int beats);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_target_state <= goal;
      // pre-edge sampling: valid and ready both high at this edge
      do @(posedge clock); while (!req_ready);
      beats = sb.note_request(act, goal);
   endtask

   // sender goes quiet, so the last beat is not taken again while waiting
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // rsp side: random stall before each beat, then hold ready until one lands
   initial begin
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_pulse(rsp_tms_bit, rsp_last_step);
      end
   end

   initial begin
      int            beats;
      int            made;
      int            i;
      action_type    act;
      tap_state_type goal;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed walk: reset from tlr, goto current state, every state of
      // both columns, the exit2 loop back into shift, long paths across
      send_action(ACT_RESET, TAP_TLR, beats);
      send_action(ACT_GOTO, TAP_TLR, beats);       // already there, no pulse
      send_action(ACT_GOTO, TAP_RTI, beats);
      send_action(ACT_GOTO, TAP_SHF_DR, beats);
      send_action(ACT_GOTO, TAP_PAU_DR, beats);
      send_action(ACT_GOTO, TAP_EX2_DR, beats);
      send_action(ACT_GOTO, TAP_SHF_DR, beats);    // exit2 back into shift
      send_action(ACT_GOTO, TAP_EX1_DR, beats);
      send_action(ACT_GOTO, TAP_UPD_DR, beats);
      send_action(ACT_GOTO, TAP_CAP_DR, beats);
      send_action(ACT_GOTO, TAP_SEL_DR, beats);
      send_action(ACT_GOTO, TAP_SEL_IR, beats);
      send_action(ACT_GOTO, TAP_CAP_IR, beats);
      send_action(ACT_GOTO, TAP_SHF_IR, beats);
      send_action(ACT_GOTO, TAP_EX1_IR, beats);
      send_action(ACT_GOTO, TAP_PAU_IR, beats);
      send_action(ACT_GOTO, TAP_EX2_IR, beats);
      send_action(ACT_GOTO, TAP_EX1_IR, beats);    // via shift-ir
      send_action(ACT_GOTO, TAP_UPD_IR, beats);
      send_action(ACT_GOTO, TAP_TLR, beats);       // select-ir escape to tlr
      send_action(ACT_GOTO, TAP_UPD_IR, beats);    // long path from tlr
      send_action(ACT_GOTO, TAP_RTI, beats);
      send_action(ACT_RESET, TAP_UPD_IR, beats);   // target bits ignored
      send_action(ACT_GOTO, TAP_RTI, beats);
      send_action(ACT_GOTO, TAP_RTI, beats);       // no pulse again

      // hold off the sender until every pulse is back
      wait_drained();

      // random part: mostly gotos to random states, some resets, a few
      // gotos to the current state that must stay silent
      made = 0;
      i    = 0;
      while (made < RANDOM_GOAL) begin
         no_idle = ((i % 50) >= 40);
         if ($urandom_range(0, 99) < 8)
            act = ACT_RESET;
         else
            act = ACT_GOTO;
         if (act == ACT_GOTO && $urandom_range(0, 99) < 5)
            goal = sb.tracked;
         else
            goal = tap_state_type'($urandom_range(0, 15));
         send_action(act, goal, beats);
         if (beats > 0)
            made++;
         if ((i % 60) == 30)
            wait_drained();
         i++;
      end
      no_idle = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("jtag_tap_state_walker_tb: done, clean");
      else
         $display("jtag_tap_state_walker_tb: done, errors");
      $finish;
   end

endmodule
